@@ rtl/core/adsr_pkg.sv @@
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types, constants and the sequencer control store of the linear
// ADSR envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned ELAPSED_W = 18;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned PC_W      = 3;
  localparam int unsigned DIV_CNT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 3'd5;

  localparam logic [LEVEL_W-1:0] PEAK_RESET = 16'hFFFF;
  localparam logic [LEVEL_W-1:0] HOLD_RESET = 16'h8000;

  localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;

  // datapath operation of one step
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_CALC,
    OP_MUL,
    OP_LD_LEVEL,
    OP_DIV,
    OP_LD_PROG,
    OP_EMIT
  } op_t;

  // branch condition: when true the sequencer jumps to the target, else falls through
  typedef enum logic [1:0] {
    BR_NEVER,
    BR_NO_INPUT,
    BR_CNT_NZ,
    BR_OUT_BUSY
  } br_t;

  typedef struct packed {
    op_t             op;
    br_t             br;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // control store
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    unique case (pc)
      3'd0:    cw = '{op: OP_WAIT,     br: BR_NO_INPUT, target: 3'd0};
      3'd1:    cw = '{op: OP_CALC,     br: BR_NEVER,    target: 3'd0};
      3'd2:    cw = '{op: OP_MUL,      br: BR_NEVER,    target: 3'd0};
      3'd3:    cw = '{op: OP_LD_LEVEL, br: BR_NEVER,    target: 3'd0};
      3'd4:    cw = '{op: OP_DIV,      br: BR_CNT_NZ,   target: 3'd4};
      3'd5:    cw = '{op: OP_LD_PROG,  br: BR_NEVER,    target: 3'd0};
      3'd6:    cw = '{op: OP_DIV,      br: BR_CNT_NZ,   target: 3'd6};
      3'd7:    cw = '{op: OP_EMIT,     br: BR_OUT_BUSY, target: 3'd7};
      default: cw = '{op: OP_WAIT,     br: BR_NEVER,    target: 3'd0};
    endcase
    return cw;
  endfunction

endpackage

@@ rtl/core/adsr_envelope_generator.sv @@
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Linear ADSR envelope with a timed sustain, driven by a small microcoded
// sequencer over one multiplier and one shared restoring divider.
// ----------------------------------------------------------------------------
// a new input word is taken only in the wait step, once the previous word is in the output register
// the shared divider (two quotient bits a cycle) runs twice per word, for
//   level and progress
// the output register lets the next input word in while a result waits
// reset: synchronous, clears the sequencer, elapsed count, armed flag and
//   output valid; registers return to their reset values, block idles
// ----------------------------------------------------------------------------
module adsr_envelope_generator (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adsr_pkg::CFG_W-1:0]       cfg_data,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [0] restart
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [39:0]                      m_axis_tdata   // [15:0] level, [18:16] phase,
                                                          // [19] active, [35:20] progress
);
  import adsr_pkg::*;

  // configuration registers
  logic [TICKS_W-1:0] attack_ticks, decay_ticks, sustain_ticks, release_ticks;
  logic [LEVEL_W-1:0] peak_level, hold_level;

  // sequencer
  logic [PC_W-1:0]      pc, pc_next;
  ctrl_word_t           cw;
  logic [DIV_CNT_W-1:0] cnt;

  // envelope state
  logic [ELAPSED_W-1:0] elapsed;
  logic                 started;

  // datapath registers
  logic [PHASE_W-1:0]   phase_q;
  logic                 active_q;
  logic [LEVEL_W-1:0]   base_q;
  logic                 sub_q;
  logic [15:0]          mul_a, mul_b;
  logic [TICKS_W-1:0]   den_lvl;
  logic [31:0]          prod;
  logic [ELAPSED_W-1:0] total_q;
  logic                 prog_zero, prog_sat;
  logic [LEVEL_W-1:0]   level_q;

  // divider
  logic [ELAPSED_W-1:0] div_rem;
  logic [15:0]          div_low;
  logic [ELAPSED_W-1:0] div_den;
  logic [15:0]          div_quo;

  // output register
  logic                 out_valid;
  logic [LEVEL_W-1:0]   out_level;
  logic [PHASE_W-1:0]   out_phase;
  logic                 out_active;
  logic [15:0]          out_progress;

  logic in_accept, out_busy;

  // ---------------------------------------------------------------- sums
  logic [ELAPSED_W-1:0] sum_ad, sum_ads, total;
  logic [LEVEL_W-1:0]   hold_eff;

  always_comb begin
    sum_ad   = {2'b00, attack_ticks} + {2'b00, decay_ticks};
    sum_ads  = sum_ad + {2'b00, sustain_ticks};
    total    = sum_ads + {2'b00, release_ticks};
    hold_eff = (hold_level < peak_level) ? hold_level : peak_level;
  end

  // ---------------------------------------------------------------- sequencer
  assign cw            = ucode(pc);
  assign s_axis_tready = (cw.op == OP_WAIT);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_busy      = out_valid && !m_axis_tready;

  always_comb begin
    logic taken;
    taken = 1'b0;
    unique case (cw.br)
      BR_NEVER:    taken = 1'b0;
      BR_NO_INPUT: taken = !in_accept;
      BR_CNT_NZ:   taken = (cnt != '0);
      BR_OUT_BUSY: taken = out_busy;
      default:     taken = 1'b0;
    endcase
    pc_next = taken ? cw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks  <= '0;
      decay_ticks   <= '0;
      sustain_ticks <= '0;
      release_ticks <= '0;
      peak_level    <= PEAK_RESET;
      hold_level    <= HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK:  attack_ticks  <= cfg_data;
        REG_DECAY:   decay_ticks   <= cfg_data;
        REG_SUSTAIN: sustain_ticks <= cfg_data;
        REG_RELEASE: release_ticks <= cfg_data;
        REG_PEAK:    peak_level    <= cfg_data;
        REG_HOLD:    hold_level    <= cfg_data;
        default:     ;
      endcase
    end
  end

  // ---------------------------------------------------------------- elapsed count
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      started <= 1'b0;
    end else if (in_accept) begin
      if (s_axis_tdata[0]) begin
        elapsed <= '0;
        started <= 1'b1;
      end else if (started) begin
        // saturate one past the end
        elapsed <= (elapsed > total) ? total + 1'b1 : elapsed + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- piece select
  logic [PHASE_W-1:0] calc_phase;
  logic [LEVEL_W-1:0] calc_base;
  logic               calc_sub;
  logic [15:0]        calc_a, calc_b;
  logic [TICKS_W-1:0] calc_den;
  logic [ELAPSED_W-1:0] t_decay, t_rel;

  always_comb begin
    t_decay    = elapsed - {2'b00, attack_ticks};
    t_rel      = elapsed - sum_ads;
    calc_phase = PH_DONE;
    calc_base  = '0;
    calc_sub   = 1'b0;
    calc_a     = '0;
    calc_b     = '0;
    calc_den   = 16'd1;
    if (started) begin
      if (elapsed < {2'b00, attack_ticks}) begin
        calc_phase = PH_ATTACK;
        calc_a     = elapsed[15:0];
        calc_b     = peak_level;
        calc_den   = attack_ticks;
      end else if (elapsed < sum_ad) begin
        calc_phase = PH_DECAY;
        calc_base  = hold_eff;
        calc_a     = peak_level - hold_eff;
        calc_b     = decay_ticks - t_decay[15:0];
        calc_den   = decay_ticks;
      end else if (elapsed < sum_ads) begin
        calc_phase = PH_SUSTAIN;
        calc_base  = hold_eff;
      end else if (elapsed < total) begin
        calc_phase = PH_RELEASE;
        calc_base  = hold_eff;
        calc_sub   = 1'b1;
        calc_a     = hold_eff;
        calc_b     = t_rel[15:0];
        calc_den   = release_ticks;
      end else if (elapsed == total) begin
        // exact end: level zero, still active
        calc_phase = PH_RELEASE;
      end
    end
  end

  // ---------------------------------------------------------------- divider step
  // two restoring steps a cycle; remainder stays below the divisor
  logic [ELAPSED_W:0]   rem1, rem2;
  logic                 ge1, ge2;
  logic [ELAPSED_W-1:0] r1, r2;

  always_comb begin
    rem1 = {div_rem, div_low[15]};
    ge1  = rem1 >= {1'b0, div_den};
    r1   = ge1 ? ELAPSED_W'(rem1 - {1'b0, div_den}) : rem1[ELAPSED_W-1:0];
    rem2 = {r1, div_low[14]};
    ge2  = rem2 >= {1'b0, div_den};
    r2   = ge2 ? ELAPSED_W'(rem2 - {1'b0, div_den}) : rem2[ELAPSED_W-1:0];
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_WAIT: ;
      OP_CALC: begin
        phase_q   <= calc_phase;
        active_q  <= started && (elapsed <= total);
        base_q    <= calc_base;
        sub_q     <= calc_sub;
        mul_a     <= calc_a;
        mul_b     <= calc_b;
        den_lvl   <= calc_den;
        total_q   <= total;
        prog_zero <= !started || (total == '0);
        prog_sat  <= elapsed >= total;
      end
      OP_MUL: begin
        prod <= mul_a * mul_b;
      end
      OP_LD_LEVEL: begin
        div_rem <= {2'b00, prod[31:16]};
        div_low <= prod[15:0];
        div_den <= {2'b00, den_lvl};
        cnt     <= '1;
      end
      OP_DIV: begin
        div_rem <= r2;
        div_low <= {div_low[13:0], 2'b00};
        div_quo <= {div_quo[13:0], ge1, ge2};
        cnt     <= cnt - 1'b1;
      end
      OP_LD_PROG: begin
        level_q <= sub_q ? base_q - div_quo : base_q + div_quo;
        // only used when elapsed is below total, so it is a proper fraction
        div_rem <= elapsed;
        div_low <= '0;
        div_den <= total_q;
        cnt     <= '1;
      end
      OP_EMIT: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_EMIT && !out_busy) begin
      out_level    <= level_q;
      out_phase    <= phase_q;
      out_active   <= active_q;
      out_progress <= prog_zero ? 16'd0 : (prog_sat ? 16'hFFFF : div_quo);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'h0, out_progress, out_active, out_phase, out_level};

endmodule
